### hw/rtl/mslsc_pkg.sv
`default_nettype none

package mslsc_pkg;

  // DC fields carried by one snapshot.
  localparam int DC_FIELDS = 4;

  // Field and datapath widths.
  localparam int N_W   = 3;   // saturated MPPT count, also shaded and producing counts
  localparam int P_W   = 30;  // dc_power * efficiency factor
  localparam int THR_W = 33;  // per-MPPT share threshold
  localparam int SUM_W = 33;  // shaded power sum and scaled target
  localparam int NUM_W = 36;  // main divider numerator
  localparam int DEN_W = 20;  // main divider denominator
  localparam int Q_W   = 16;  // quotient and result limit

  // Fixed-point constants.
  localparam logic [13:0] DEFAULT_EFF = 14'd9670;
  localparam logic [16:0] THR_SCALE   = 17'd98000;
  localparam logic [16:0] X_SCALE     = 17'd100000;
  localparam logic [15:0] LOW_STEP    = 16'd10;   // watts per channel for the low limit test
  localparam logic [15:0] PROD_STEP   = 16'd20;   // 0.1 W per channel for a producing MPPT
  localparam logic [19:0] AC_SCALE    = 20'd10;

  // Configuration register indexes.
  localparam logic REG_OVERSCALE = 1'b0;
  localparam logic REG_CHAN      = 1'b1;

  // Reason codes.
  localparam logic [3:0] RSN_NOT_PROD   = 4'd0;
  localparam logic [3:0] RSN_SINGLE     = 4'd1;
  localparam logic [3:0] RSN_LIMIT_LOW  = 4'd2;
  localparam logic [3:0] RSN_NO_SHADE   = 4'd3;
  localparam logic [3:0] RSN_KEEP       = 4'd4;
  localparam logic [3:0] RSN_ALL_SHADED = 4'd5;
  localparam logic [3:0] RSN_OVS_SMALL  = 4'd6;
  localparam logic [3:0] RSN_OVERSCALED = 4'd7;
  localparam logic [3:0] RSN_ALL_PROD   = 4'd8;
  localparam logic [3:0] RSN_SCALED     = 4'd9;

  // Snapshot context carried down the front of the pipeline.
  typedef struct packed {
    logic [15:0]                 lim;
    logic [15:0]                 x;
    logic [15:0]                 ac10;
    logic [13:0]                 f;
    logic [DC_FIELDS-1:0][15:0]  dc;
    logic [N_W-1:0]              n;
    logic                        bypass;
    logic [3:0]                  reason;
  } ctx_t;

  // Per-lane findings handed to the merge stage.
  typedef struct packed {
    logic            shaded;
    logic            producing;
    logic [P_W-1:0]  psum;
  } lane_t;

  // Decision carried alongside the main division.
  typedef struct packed {
    logic            pending;
    logic            plain;
    logic [3:0]      reason;
    logic [15:0]     value;
    logic [15:0]     x;
    logic [N_W-1:0]  n;
  } dec_t;

endpackage

`default_nettype wire

### hw/rtl/mslsc_div.sv
`default_nettype none

// Pipelined restoring divider, one quotient bit per stage. The first stage
// flags quotients that do not fit in Q_W bits; those come out as all ones.
module mslsc_div #(
  parameter int NUM_W  = 36,
  parameter int DEN_W  = 20,
  parameter int Q_W    = 16,
  parameter int SIDE_W = 1
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              up_valid,
  output logic                   up_ready,
  input  wire logic [NUM_W-1:0]  num,
  input  wire logic [DEN_W-1:0]  den,
  input  wire logic [SIDE_W-1:0] up_side,
  output logic                   dn_valid,
  input  wire logic              dn_ready,
  output logic [Q_W-1:0]         quo,
  output logic [SIDE_W-1:0]      dn_side
);

  localparam int W      = (NUM_W > DEN_W + Q_W) ? NUM_W : DEN_W + Q_W;
  localparam int STAGES = Q_W + 1;

  logic [STAGES-1:0] vld_r;
  logic [STAGES:0]   rdy;
  logic [W-1:0]      rem_r  [Q_W];
  logic [W-1:0]      den_r  [Q_W];
  logic [Q_W-1:0]    q_r    [STAGES];
  logic              sat_r  [STAGES];
  logic [SIDE_W-1:0] side_r [STAGES];
  logic [Q_W:1]      ge;
  logic [W-1:0]      sub    [Q_W+1];

  // A stage takes new data when it is empty or its successor moves on.
  assign rdy[STAGES] = dn_ready;
  for (genvar s = 0; s < STAGES; s++) begin : g_rdy
    assign rdy[s] = !vld_r[s] || rdy[s+1];
  end

  always_comb begin
    sub[0] = '0;
    for (int s = 1; s <= Q_W; s++) begin
      sub[s] = den_r[s-1] << (Q_W - s);
      ge[s]  = rem_r[s-1] >= sub[s];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (rdy[0]) begin
        vld_r[0] <= up_valid;
      end
      for (int s = 1; s < STAGES; s++) begin
        if (rdy[s]) begin
          vld_r[s] <= vld_r[s-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      rem_r[0]  <= W'(num);
      den_r[0]  <= W'(den);
      q_r[0]    <= '0;
      sat_r[0]  <= W'(num) >= (W'(den) << Q_W);
      side_r[0] <= up_side;
    end
    for (int s = 1; s < Q_W; s++) begin
      if (rdy[s]) begin
        rem_r[s]  <= ge[s] ? rem_r[s-1] - sub[s] : rem_r[s-1];
        den_r[s]  <= den_r[s-1];
        q_r[s]    <= ge[s] ? (q_r[s-1] | (Q_W'(1) << (Q_W - s))) : q_r[s-1];
        sat_r[s]  <= sat_r[s-1];
        side_r[s] <= side_r[s-1];
      end
    end
    if (rdy[Q_W]) begin
      q_r[Q_W]    <= ge[Q_W] ? (q_r[Q_W-1] | Q_W'(1)) : q_r[Q_W-1];
      sat_r[Q_W]  <= sat_r[Q_W-1];
      side_r[Q_W] <= side_r[Q_W-1];
    end
  end

  assign up_ready = rdy[0];
  assign dn_valid = vld_r[Q_W];
  assign quo      = sat_r[Q_W] ? '1 : q_r[Q_W];
  assign dn_side  = side_r[Q_W];

endmodule

`default_nettype wire

### hw/rtl/mslsc_lane.sv
`default_nettype none

// One MPPT lane: AC-equivalent power, shaded test and producing test.
module mslsc_lane (
  input  wire logic                          clk,
  input  wire logic                          en_p,
  input  wire logic                          en_c,
  input  wire logic                          active,
  input  wire logic [15:0]                   dc,
  input  wire logic [13:0]                   f,
  input  wire logic [2:0]                    chan,
  input  wire logic [mslsc_pkg::THR_W-1:0]   thr,
  output mslsc_pkg::lane_t                   lane_o
);

  logic [mslsc_pkg::P_W-1:0] p_r;
  logic                      prod_r;
  logic                      act_r;
  mslsc_pkg::lane_t          lane_r;
  logic                      shaded;

  always_ff @(posedge clk) begin
    if (en_p) begin
      p_r    <= mslsc_pkg::P_W'(dc) * mslsc_pkg::P_W'(f);
      prod_r <= active && (dc > (16'(chan) * mslsc_pkg::PROD_STEP));
      act_r  <= active;
    end
  end

  assign shaded = act_r && (mslsc_pkg::THR_W'(p_r) < thr);

  always_ff @(posedge clk) begin
    if (en_c) begin
      lane_r.shaded    <= shaded;
      lane_r.producing <= prod_r;
      lane_r.psum      <= shaded ? p_r : '0;
    end
  end

  assign lane_o = lane_r;

endmodule

`default_nettype wire

### hw/rtl/mslsc_merge.sv
`default_nettype none

// Merge of the lane findings: counts and sums, mode decision, and the
// operands for the main division. Three registered stages.
module mslsc_merge #(
  parameter int LANES = 4
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            overscale,
  input  wire logic                            up_valid,
  output logic                                 up_ready,
  input  wire mslsc_pkg::ctx_t                 ctx,
  input  wire mslsc_pkg::lane_t [LANES-1:0]    lanes,
  output logic                                 dn_valid,
  input  wire logic                            dn_ready,
  output logic [mslsc_pkg::NUM_W-1:0]          num,
  output logic [mslsc_pkg::DEN_W-1:0]          den,
  output mslsc_pkg::dec_t                      dec
);

  logic [2:0] vld_r;
  logic [3:0] rdy;

  // Stage 1: totals over the lanes.
  logic [mslsc_pkg::N_W-1:0]   k_nxt, k_r;
  logic [mslsc_pkg::N_W-1:0]   pc_nxt, pc_r;
  logic [mslsc_pkg::SUM_W-1:0] sum_nxt, sum_r;
  logic [mslsc_pkg::SUM_W-1:0] xs_r;
  mslsc_pkg::ctx_t             ctx1_r;

  // Stage 2: decision and denominator.
  mslsc_pkg::dec_t             dec_nxt, dec2_r;
  logic [mslsc_pkg::DEN_W-1:0] den_nxt, den2_r;
  logic [mslsc_pkg::SUM_W-1:0] diff2_r;

  // Stage 3: numerator.
  mslsc_pkg::dec_t             dec3_r;
  logic [mslsc_pkg::DEN_W-1:0] den3_r;
  logic [mslsc_pkg::NUM_W-1:0] num3_r;

  assign rdy[3] = dn_ready;
  assign rdy[2] = !vld_r[2] || rdy[3];
  assign rdy[1] = !vld_r[1] || rdy[2];
  assign rdy[0] = !vld_r[0] || rdy[1];

  always_comb begin
    k_nxt   = '0;
    pc_nxt  = '0;
    sum_nxt = '0;
    for (int i = 0; i < LANES; i++) begin
      k_nxt   = k_nxt + mslsc_pkg::N_W'(lanes[i].shaded);
      pc_nxt  = pc_nxt + mslsc_pkg::N_W'(lanes[i].producing);
      sum_nxt = sum_nxt + mslsc_pkg::SUM_W'(lanes[i].psum);
    end
  end

  always_comb begin
    dec_nxt         = '0;
    dec_nxt.x       = ctx1_r.x;
    dec_nxt.n       = ctx1_r.n;
    dec_nxt.value   = ctx1_r.x;
    dec_nxt.reason  = ctx1_r.reason;
    if (ctx1_r.bypass) begin
      dec_nxt.reason = ctx1_r.reason;
    end else if (overscale) begin
      if (k_r == '0 || sum_r >= xs_r) begin
        dec_nxt.reason = mslsc_pkg::RSN_NO_SHADE;
      end else if (k_r == ctx1_r.n) begin
        if (ctx1_r.lim >= ctx1_r.x &&
            20'(ctx1_r.ac10) <= 20'(ctx1_r.x) * mslsc_pkg::AC_SCALE) begin
          dec_nxt.value  = ctx1_r.lim;
          dec_nxt.reason = mslsc_pkg::RSN_KEEP;
        end else begin
          dec_nxt.reason = mslsc_pkg::RSN_ALL_SHADED;
        end
      end else begin
        dec_nxt.pending = 1'b1;
        dec_nxt.reason  = mslsc_pkg::RSN_OVERSCALED;
      end
    end else begin
      if (pc_r == '0 || pc_r == ctx1_r.n) begin
        dec_nxt.reason = mslsc_pkg::RSN_ALL_PROD;
      end else begin
        dec_nxt.pending = 1'b1;
        dec_nxt.plain   = 1'b1;
        dec_nxt.reason  = mslsc_pkg::RSN_SCALED;
      end
    end
    if (overscale) begin
      den_nxt = mslsc_pkg::DEN_W'(ctx1_r.n - k_r) * mslsc_pkg::DEN_W'(mslsc_pkg::X_SCALE);
    end else begin
      den_nxt = mslsc_pkg::DEN_W'(pc_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (rdy[0]) vld_r[0] <= up_valid;
      if (rdy[1]) vld_r[1] <= vld_r[0];
      if (rdy[2]) vld_r[2] <= vld_r[1];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      k_r    <= k_nxt;
      pc_r   <= pc_nxt;
      sum_r  <= sum_nxt;
      xs_r   <= mslsc_pkg::SUM_W'(ctx.x) * mslsc_pkg::SUM_W'(mslsc_pkg::X_SCALE);
      ctx1_r <= ctx;
    end
    if (rdy[1]) begin
      dec2_r  <= dec_nxt;
      den2_r  <= den_nxt;
      diff2_r <= xs_r - sum_r;
    end
    if (rdy[2]) begin
      dec3_r <= dec2_r;
      den3_r <= den2_r;
      num3_r <= dec2_r.plain ? mslsc_pkg::NUM_W'(dec2_r.x)
                             : mslsc_pkg::NUM_W'(diff2_r) * mslsc_pkg::NUM_W'(dec2_r.n);
    end
  end

  assign up_ready = rdy[0];
  assign dn_valid = vld_r[2];
  assign num      = num3_r;
  assign den      = den3_r;
  assign dec      = dec3_r;

endmodule

`default_nettype wire

### hw/rtl/mppt_shading_limit_scaler_top.sv
`default_nettype none

// Channel   Direction  Handshake                 Payload
// in_       slave      in_tvalid / in_tready     in_tdata, 136 bits, one snapshot
// out_      master     out_tvalid / out_tready   out_tdata, 24 bits, limit and reason
// cfg_      write      cfg_wr_en                 cfg_index, cfg_wdata
//
// One transaction is accepted per clock unless the output stalls; every
// snapshot is independent. Stages: input register, 17 of the share divider
// (lim / n), 2 lane stages, 3 merge stages, 17 of the main divider and the
// output register. Both dividers retire one quotient bit per stage.
// Reset (rst_n low at a clock edge) clears all valid flags and loads the
// configuration defaults; no clearing pass follows. Each stage advances into
// an empty successor, so a stalled output only holds the stages behind it
// once they are all full.
module mppt_shading_limit_scaler_top #(
  parameter int MPPT_MAX = 4
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // From bit 0: producing, mppt_count[2:0], current_limit[15:0],
  // expected_output[15:0], inverter_ac_power[15:0], efficiency[13:0],
  // dc_power_a..dc_power_d[15:0] each, six zero bits.
  input  wire logic [135:0] in_tdata,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // From bit 0: scaled_limit[15:0], reason[3:0], four zero bits.
  output logic [23:0]       out_tdata,
  input  wire logic         cfg_wr_en,
  input  wire logic [0:0]   cfg_index,
  input  wire logic [2:0]   cfg_wdata
);

  localparam int LANES = MPPT_MAX;
  localparam int CTX_W = $bits(mslsc_pkg::ctx_t);
  localparam int DEC_W = $bits(mslsc_pkg::dec_t);

  // Configuration registers; the user changes them only while the pipeline is empty.
  logic       cfg_overscale_r;
  logic [2:0] cfg_chan_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_overscale_r <= 1'b0;
      cfg_chan_r      <= 3'd1;
    end else if (cfg_wr_en) begin
      unique case (cfg_index[0])
        mslsc_pkg::REG_OVERSCALE: cfg_overscale_r <= cfg_wdata[0];
        mslsc_pkg::REG_CHAN:      cfg_chan_r      <= cfg_wdata;
      endcase
    end
  end

  // Input stage: unpack the snapshot, saturate the MPPT count, pick the
  // efficiency factor and settle the cases that pass the target through.
  logic                          in_producing;
  logic [2:0]                    in_mppt_count;
  logic [15:0]                   in_current_limit;
  logic [13:0]                   in_efficiency;
  logic [mslsc_pkg::N_W-1:0]     n_sat;
  logic [9:0]                    low_floor;
  mslsc_pkg::ctx_t               ctx0_nxt, ctx0_r;
  logic                          v0_r;
  logic                          thr_up_ready;

  assign in_producing     = in_tdata[0];
  assign in_mppt_count    = in_tdata[3:1];
  assign in_current_limit = in_tdata[19:4];
  assign in_efficiency    = in_tdata[65:52];

  always_comb begin
    n_sat     = ({1'b0, in_mppt_count} > 4'(MPPT_MAX)) ? mslsc_pkg::N_W'(MPPT_MAX)
                                                       : in_mppt_count;
    low_floor = 10'(n_sat) * 10'(cfg_chan_r) * 10'(mslsc_pkg::LOW_STEP);

    ctx0_nxt        = '0;
    ctx0_nxt.lim    = in_current_limit;
    ctx0_nxt.x      = in_tdata[35:20];
    ctx0_nxt.ac10   = in_tdata[51:36];
    ctx0_nxt.f      = (in_efficiency == '0) ? mslsc_pkg::DEFAULT_EFF : in_efficiency;
    ctx0_nxt.dc[0]  = in_tdata[81:66];
    ctx0_nxt.dc[1]  = in_tdata[97:82];
    ctx0_nxt.dc[2]  = in_tdata[113:98];
    ctx0_nxt.dc[3]  = in_tdata[129:114];
    ctx0_nxt.n      = n_sat;
    ctx0_nxt.bypass = 1'b1;
    if (!in_producing) begin
      ctx0_nxt.reason = mslsc_pkg::RSN_NOT_PROD;
    end else if (n_sat <= mslsc_pkg::N_W'(1)) begin
      ctx0_nxt.reason = mslsc_pkg::RSN_SINGLE;
    end else if (in_current_limit < 16'(low_floor)) begin
      ctx0_nxt.reason = mslsc_pkg::RSN_LIMIT_LOW;
    end else begin
      ctx0_nxt.bypass = 1'b0;
      ctx0_nxt.reason = mslsc_pkg::RSN_NO_SHADE;
    end
  end

  assign in_tready = !v0_r || thr_up_ready;

  // Share divider: floor(current_limit / n) with the context riding along.
  logic                  thr_valid;
  logic [15:0]           thr_quo;
  logic [CTX_W-1:0]      thr_side;
  mslsc_pkg::ctx_t       ctxt;
  logic                  rdy_p;

  mslsc_div #(
    .NUM_W  (16),
    .DEN_W  (mslsc_pkg::N_W),
    .Q_W    (16),
    .SIDE_W (CTX_W)
  ) u_thr_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (v0_r),
    .up_ready (thr_up_ready),
    .num      (ctx0_r.lim),
    .den      (ctx0_r.n),
    .up_side  (ctx0_r),
    .dn_valid (thr_valid),
    .dn_ready (rdy_p),
    .quo      (thr_quo),
    .dn_side  (thr_side)
  );

  assign ctxt = mslsc_pkg::ctx_t'(thr_side);

  // Lane stages: power products and the threshold in the first, the
  // compares in the second.
  logic                          vp_r, vc_r;
  logic                          rdy_c;
  logic                          mrg_up_ready;
  mslsc_pkg::ctx_t               ctxp_r, ctxc_r;
  logic [mslsc_pkg::THR_W-1:0]   thrp_r;
  mslsc_pkg::lane_t [LANES-1:0]  lane_res;

  assign rdy_p = !vp_r || rdy_c;
  assign rdy_c = !vc_r || mrg_up_ready;

  for (genvar i = 0; i < LANES; i++) begin : g_lane
    logic [15:0] lane_dc;
    logic        lane_act;

    if (i < mslsc_pkg::DC_FIELDS) begin : g_dc
      assign lane_dc = ctxt.dc[i];
    end else begin : g_zero
      assign lane_dc = '0;
    end

    assign lane_act = 4'(i) < {1'b0, ctxt.n};

    mslsc_lane u_lane (
      .clk    (clk),
      .en_p   (rdy_p),
      .en_c   (rdy_c),
      .active (lane_act),
      .dc     (lane_dc),
      .f      (ctxt.f),
      .chan   (cfg_chan_r),
      .thr    (thrp_r),
      .lane_o (lane_res[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      vp_r <= 1'b0;
      vc_r <= 1'b0;
    end else begin
      if (in_tready) v0_r <= in_tvalid;
      if (rdy_p)     vp_r <= thr_valid;
      if (rdy_c)     vc_r <= vp_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready) begin
      ctx0_r <= ctx0_nxt;
    end
    if (rdy_p) begin
      ctxp_r <= ctxt;
      thrp_r <= mslsc_pkg::THR_W'(thr_quo) * mslsc_pkg::THR_W'(mslsc_pkg::THR_SCALE);
    end
    if (rdy_c) begin
      ctxc_r <= ctxp_r;
    end
  end

  // Merge of the lanes into the division operands and the decision.
  logic                          mrg_valid;
  logic                          div_up_ready;
  logic [mslsc_pkg::NUM_W-1:0]   mrg_num;
  logic [mslsc_pkg::DEN_W-1:0]   mrg_den;
  mslsc_pkg::dec_t               mrg_dec;

  mslsc_merge #(
    .LANES (LANES)
  ) u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .overscale (cfg_overscale_r),
    .up_valid  (vc_r),
    .up_ready  (mrg_up_ready),
    .ctx       (ctxc_r),
    .lanes     (lane_res),
    .dn_valid  (mrg_valid),
    .dn_ready  (div_up_ready),
    .num       (mrg_num),
    .den       (mrg_den),
    .dec       (mrg_dec)
  );

  // Main divider: overscaled limit or target per producing MPPT. A quotient
  // that does not fit comes out as 65535, which is the saturated limit.
  logic                       div_valid;
  logic                       rdy_f;
  logic [mslsc_pkg::Q_W-1:0]  div_quo;
  logic [DEC_W-1:0]           div_side;
  mslsc_pkg::dec_t            decm;

  mslsc_div #(
    .NUM_W  (mslsc_pkg::NUM_W),
    .DEN_W  (mslsc_pkg::DEN_W),
    .Q_W    (mslsc_pkg::Q_W),
    .SIDE_W (DEC_W)
  ) u_main_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (mrg_valid),
    .up_ready (div_up_ready),
    .num      (mrg_num),
    .den      (mrg_den),
    .up_side  (mrg_dec),
    .dn_valid (div_valid),
    .dn_ready (rdy_f),
    .quo      (div_quo),
    .dn_side  (div_side)
  );

  assign decm = mslsc_pkg::dec_t'(div_side);

  // Output stage: plain scaling multiplies back by n and saturates; the
  // overscaled limit only replaces the target when it is above it.
  logic [18:0] scaled;
  logic [15:0] res_val;
  logic [3:0]  res_rsn;
  logic        out_valid_r;
  logic [23:0] out_data_r;

  always_comb begin
    scaled  = 19'(div_quo) * 19'(decm.n);
    res_val = decm.value;
    res_rsn = decm.reason;
    if (decm.pending) begin
      if (decm.plain) begin
        res_val = (scaled > 19'(16'hFFFF)) ? 16'hFFFF : scaled[15:0];
        res_rsn = mslsc_pkg::RSN_SCALED;
      end else if (div_quo <= decm.x) begin
        res_val = decm.x;
        res_rsn = mslsc_pkg::RSN_OVS_SMALL;
      end else begin
        res_val = div_quo;
        res_rsn = mslsc_pkg::RSN_OVERSCALED;
      end
    end
  end

  assign rdy_f = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (rdy_f) begin
      out_valid_r <= div_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_f) begin
      out_data_r <= {4'b0000, res_rsn, res_val};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

`default_nettype wire

### bench/tb_top.sv
`default_nettype none

// Testbench for the MPPT shading limit scaler. Snapshots go in as stream
// transactions, and every snapshot produces exactly one limit transaction.
// The bench predicts each limit and reason code itself, keeps the predictions
// in order, and compares every returned transaction against the oldest one.
module tb_top;

  localparam int MPPT_MAX = 4;

  // Pipeline depth given by the block, plus the bench's own timing knobs.
  localparam int LATENCY     = 41;
  localparam int LONG_STALL  = 200;   // receiver hold-off that fills the pipeline
  localparam int STALL_LIMIT = 3000;  // cycles without any transaction before giving up
  localparam int BLOCK_ITEMS = 50;    // snapshots between register changes

  // Fixed-point constants of the limit arithmetic.
  localparam longint unsigned EFF_DEFAULT  = 9670;    // 96.70 %
  localparam longint unsigned SHARE_SCALE  = 98000;   // 98 % of a watt in 1e-5 W
  localparam longint unsigned TARGET_SCALE = 100000;  // one watt in 1e-5 W
  localparam longint unsigned LOW_W_PER_CH = 10;      // minimum limit per channel, W
  localparam longint unsigned PROD_PER_CH  = 20;      // producing threshold, 0.1 W
  localparam longint unsigned AC_TENTHS    = 10;
  localparam longint unsigned LIMIT_MAX    = 65535;

  // One snapshot, declared from the top bit down so that the packed value
  // matches in_tdata with producing in bit 0.
  typedef struct packed {
    logic [mslsc_pkg::DC_FIELDS-1:0][15:0] dc;
    logic [13:0]                           efficiency;
    logic [15:0]                           ac_power;
    logic [15:0]                           expected_output;
    logic [15:0]                           current_limit;
    logic [2:0]                            mppt_count;
    logic                                  producing;
  } snapshot_t;

  // One result, scaled_limit in the low bits.
  typedef struct packed {
    logic [3:0]  reason;
    logic [15:0] scaled_limit;
  } limit_result_t;

  logic clk;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  // From bit 0: producing, mppt_count, current_limit, expected_output,
  // inverter_ac_power, efficiency, dc_power_a..dc_power_d, zero padding.
  logic [135:0] in_tdata;
  logic out_tvalid;
  logic out_tready;
  // From bit 0: scaled_limit, reason, zero padding.
  logic [23:0] out_tdata;
  logic cfg_wr_en;
  logic [0:0] cfg_index;
  logic [2:0] cfg_wdata;

  // Shadow copy of the configuration registers used by the predictor.
  bit       overscale_mode;
  bit [2:0] channels_per_mppt;

  limit_result_t pending_limits[$];

  int send_idle_pct;
  int recv_idle_pct;
  bit long_stall_req;
  int mismatches;
  int snapshots_sent;
  int results_checked;
  int config_writes;
  bit [15:0] reasons_seen;

  mppt_shading_limit_scaler_top #(
    .MPPT_MAX(MPPT_MAX)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Computes the limit and reason for one snapshot under the current register
  // settings. All products stay exact in 64 bits, so only the divisions
  // truncate, as the block is specified to do.
  function automatic limit_result_t predict_limit(snapshot_t s);
    longint unsigned n;
    longint unsigned lim;
    longint unsigned x;
    longint unsigned f;
    longint unsigned thr;
    longint unsigned target;
    longint unsigned shaded_sum;
    longint unsigned shaded_cnt;
    longint unsigned prod_cnt;
    longint unsigned p;
    longint unsigned v;
    limit_result_t r;
    n = 64'(s.mppt_count);
    if (n > 64'(MPPT_MAX)) n = 64'(MPPT_MAX);
    lim = 64'(s.current_limit);
    x = 64'(s.expected_output);
    r.scaled_limit = s.expected_output;
    if (!s.producing) begin
      r.reason = mslsc_pkg::RSN_NOT_PROD;
    end else if (n <= 1) begin
      r.reason = mslsc_pkg::RSN_SINGLE;
    end else if (lim < n * 64'(channels_per_mppt) * LOW_W_PER_CH) begin
      r.reason = mslsc_pkg::RSN_LIMIT_LOW;
    end else if (overscale_mode) begin
      f = (s.efficiency != 0) ? 64'(s.efficiency) : EFF_DEFAULT;
      thr = (lim / n) * SHARE_SCALE;
      target = x * TARGET_SCALE;
      shaded_sum = 0;
      shaded_cnt = 0;
      for (int i = 0; i < n; i++) begin
        p = 0;
        if (i < mslsc_pkg::DC_FIELDS) p = 64'(s.dc[i]) * f;
        if (p < thr) begin
          shaded_cnt++;
          shaded_sum += p;
        end
      end
      if (shaded_cnt == 0 || shaded_sum >= target) begin
        r.reason = mslsc_pkg::RSN_NO_SHADE;
      end else if (shaded_cnt == n) begin
        // Every MPPT is shaded: keep the present limit only when it already
        // covers the target and the inverter is not above the target.
        if (lim >= x && 64'(s.ac_power) <= x * AC_TENTHS) begin
          r.scaled_limit = s.current_limit;
          r.reason = mslsc_pkg::RSN_KEEP;
        end else begin
          r.reason = mslsc_pkg::RSN_ALL_SHADED;
        end
      end else begin
        v = ((target - shaded_sum) * n) / ((n - shaded_cnt) * TARGET_SCALE);
        if (v > LIMIT_MAX) v = LIMIT_MAX;
        if (v <= x) begin
          r.reason = mslsc_pkg::RSN_OVS_SMALL;
        end else begin
          r.scaled_limit = v[15:0];
          r.reason = mslsc_pkg::RSN_OVERSCALED;
        end
      end
    end else begin
      prod_cnt = 0;
      for (int i = 0; i < n; i++) begin
        p = 0;
        if (i < mslsc_pkg::DC_FIELDS) p = 64'(s.dc[i]);
        if (p > PROD_PER_CH * 64'(channels_per_mppt)) prod_cnt++;
      end
      if (prod_cnt == 0 || prod_cnt == n) begin
        r.reason = mslsc_pkg::RSN_ALL_PROD;
      end else begin
        v = (x / prod_cnt) * n;
        if (v > LIMIT_MAX) v = LIMIT_MAX;
        r.scaled_limit = v[15:0];
        r.reason = mslsc_pkg::RSN_SCALED;
      end
    end
    return r;
  endfunction

  function automatic snapshot_t mk_snapshot(bit producing, int n, int lim, int x, int ac,
                                            int eff, int a, int b, int c, int d);
    snapshot_t s;
    s.producing = producing;
    s.mppt_count = 3'(n);
    s.current_limit = 16'(lim);
    s.expected_output = 16'(x);
    s.ac_power = 16'(ac);
    s.efficiency = 14'(eff);
    s.dc[0] = 16'(a);
    s.dc[1] = 16'(b);
    s.dc[2] = 16'(c);
    s.dc[3] = 16'(d);
    return s;
  endfunction

  // Random snapshot. A fifth of them are raw noise over every bit; the rest
  // are plausible snapshots whose DC powers sit around the per-MPPT share or
  // around the producing threshold, so that the shading and scaling paths
  // are reached far more often than random bits would reach them.
  function automatic snapshot_t random_snapshot();
    snapshot_t s;
    longint unsigned share_dc;
    longint unsigned tmp;
    int unsigned nn;
    s.producing = 1'($urandom);
    s.mppt_count = 3'($urandom);
    s.current_limit = 16'($urandom);
    s.expected_output = 16'($urandom);
    s.ac_power = 16'($urandom);
    s.efficiency = 14'($urandom);
    for (int i = 0; i < mslsc_pkg::DC_FIELDS; i++) s.dc[i] = 16'($urandom);
    if ($urandom_range(99) < 20) return s;

    s.producing = ($urandom_range(19) != 0);
    s.mppt_count = ($urandom_range(9) == 0) ? 3'($urandom_range(7))
                                            : 3'($urandom_range(4, 2));
    case ($urandom_range(3))
      0: s.current_limit = 16'($urandom_range(120));
      1, 2: s.current_limit = 16'($urandom_range(8000, 100));
      default: s.current_limit = 16'($urandom);
    endcase
    case ($urandom_range(3))
      0: s.expected_output = 16'($urandom_range(32'(s.current_limit)));
      1: begin
        tmp = 64'(s.current_limit) + 64'($urandom_range(20));
        s.expected_output = 16'((tmp > LIMIT_MAX) ? LIMIT_MAX : tmp);
      end
      2: s.expected_output = 16'($urandom);
      default: s.expected_output = 16'($urandom_range(300));
    endcase
    // Measured power lands right around the target more often than not.
    tmp = 64'(s.expected_output) * AC_TENTHS + 64'($urandom_range(2));
    tmp = (tmp > 0) ? tmp - 1 : 0;
    if ($urandom_range(3) == 0) tmp = 64'($urandom_range(65535));
    s.ac_power = 16'((tmp > LIMIT_MAX) ? LIMIT_MAX : tmp);
    case ($urandom_range(9))
      0, 1: s.efficiency = '0;
      2: s.efficiency = 14'($urandom);
      default: s.efficiency = 14'($urandom_range(10000, 9000));
    endcase
    nn = (s.mppt_count > MPPT_MAX) ? 32'(MPPT_MAX)
                                   : ((s.mppt_count == 0) ? 32'd1 : 32'(s.mppt_count));
    share_dc = 64'(32'(s.current_limit) / nn) * 10;
    for (int i = 0; i < mslsc_pkg::DC_FIELDS; i++) begin
      case ($urandom_range(3))
        0: tmp = 64'($urandom_range(200));
        1, 2: tmp = (share_dc * 64'($urandom_range(120, 80))) / 100;
        default: tmp = 64'($urandom_range(65535));
      endcase
      s.dc[i] = 16'((tmp > LIMIT_MAX) ? LIMIT_MAX : tmp);
    end
    return s;
  endfunction

  task automatic report_mismatch(string what, longint unsigned want, longint unsigned got);
    mismatches++;
    $display("MISMATCH %s: expected %0d, got %0d at %0t", what, want, got, $time);
  endtask

  // Offers one snapshot, with a random gap in front of it, and records its
  // predicted result once the transaction is accepted.
  task automatic send_snapshot(snapshot_t s);
    int gap;
    gap = 0;
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) gap++;
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {6'b0, s};
    do @(posedge clk); while (!in_tready);
    pending_limits.insert(pending_limits.size(), predict_limit(s));
    snapshots_sent++;
  endtask

  // Stops offering snapshots until every predicted result has come back.
  task automatic wait_all_results();
    in_tvalid <= 1'b0;
    while (pending_limits.size() != 0) @(posedge clk);
  endtask

  // Writes both registers; only called while the pipeline is empty.
  task automatic set_config(bit ovs, bit [2:0] chan);
    cfg_wr_en <= 1'b1;
    cfg_index <= mslsc_pkg::REG_OVERSCALE;
    cfg_wdata <= {2'b0, ovs};
    @(posedge clk);
    cfg_index <= mslsc_pkg::REG_CHAN;
    cfg_wdata <= chan;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    overscale_mode = ovs;
    channels_per_mppt = chan;
    config_writes++;
  endtask

  // Plain scaling straight out of reset, which also checks the register
  // defaults: one channel per MPPT and overscaling off.
  task automatic test_plain_directed();
    send_snapshot(mk_snapshot(0, 4, 1000, 500, 0, 0, 100, 100, 100, 100));
    send_snapshot(mk_snapshot(1, 0, 1000, 500, 0, 0, 100, 100, 100, 100));
    send_snapshot(mk_snapshot(1, 1, 1000, 500, 0, 0, 100, 0, 0, 0));
    send_snapshot(mk_snapshot(1, 4, 39, 30, 0, 0, 100, 100, 100, 100));
    send_snapshot(mk_snapshot(1, 4, 1000, 800, 0, 0, 100, 100, 100, 100));
    send_snapshot(mk_snapshot(1, 4, 1000, 800, 0, 0, 0, 20, 5, 20));
    send_snapshot(mk_snapshot(1, 4, 1000, 801, 0, 0, 100, 21, 0, 0));
    // A count above the maximum folds down to four; the scaled value saturates.
    send_snapshot(mk_snapshot(1, 7, 1000, 65535, 0, 0, 65535, 0, 0, 0));
    send_snapshot(mk_snapshot(1, 3, 65535, 65535, 65535, 16383, 65535, 65535, 0, 0));
    wait_all_results();
  endtask

  // Shading compensation around the 98 % share threshold. With a limit of
  // 4000 W over four MPPTs at 100 % efficiency, 980.0 W DC is exactly on the
  // threshold and counts as unshaded, 979.9 W counts as shaded.
  task automatic test_shading_directed();
    set_config(1'b1, 3'd1);
    send_snapshot(mk_snapshot(1, 4, 4000, 3000, 0, 10000, 9800, 9800, 9800, 9800));
    send_snapshot(mk_snapshot(1, 4, 4000, 10, 0, 10000, 9799, 9800, 9800, 9800));
    send_snapshot(mk_snapshot(1, 4, 4000, 3000, 30000, 10000, 100, 100, 100, 100));
    send_snapshot(mk_snapshot(1, 4, 4000, 3000, 30001, 10000, 100, 100, 100, 100));
    send_snapshot(mk_snapshot(1, 4, 4000, 5000, 0, 10000, 100, 100, 100, 100));
    send_snapshot(mk_snapshot(1, 4, 4000, 3000, 0, 10000, 0, 0, 9800, 9800));
    send_snapshot(mk_snapshot(1, 4, 4000, 3000, 0, 10000, 9000, 9800, 9800, 9800));
    // Overscaling that saturates: above the target once, equal to it once.
    send_snapshot(mk_snapshot(1, 2, 20000, 40000, 0, 16383, 65535, 0, 0, 0));
    send_snapshot(mk_snapshot(1, 2, 20000, 65535, 0, 16383, 65535, 0, 0, 0));
    // Zero efficiency selects 96.70 %; these two straddle the threshold.
    send_snapshot(mk_snapshot(1, 2, 2000, 1500, 0, 0, 10134, 10135, 0, 0));
    send_snapshot(mk_snapshot(1, 7, 4000, 3000, 0, 10000, 0, 9800, 9800, 9800));
    wait_all_results();
  endtask

  // Channel counts at and beyond the nominal range. Zero channels disables
  // the low-limit test and makes any nonzero DC power count as producing.
  task automatic test_channel_extremes();
    set_config(1'b0, 3'd7);
    send_snapshot(mk_snapshot(1, 4, 279, 200, 0, 0, 140, 141, 0, 0));
    send_snapshot(mk_snapshot(1, 4, 280, 200, 0, 0, 140, 141, 0, 0));
    wait_all_results();
    set_config(1'b0, 3'd0);
    send_snapshot(mk_snapshot(1, 4, 0, 500, 0, 0, 1, 0, 0, 0));
    wait_all_results();
    set_config(1'b1, 3'd0);
    send_snapshot(mk_snapshot(1, 4, 0, 500, 0, 0, 0, 0, 0, 0));
    wait_all_results();
    set_config(1'b1, 3'd4);
    send_snapshot(mk_snapshot(1, 2, 79, 50, 0, 0, 0, 0, 0, 0));
    wait_all_results();
  endtask

  // Random snapshots in blocks; between blocks the pipeline drains and the
  // registers take a new setting, mostly within the nominal channel range.
  task automatic test_random_traffic(int sender_pct, int receiver_pct, int items);
    bit [2:0] chan;
    send_idle_pct = sender_pct;
    recv_idle_pct = receiver_pct;
    for (int done = 0; done < items; done += BLOCK_ITEMS) begin
      wait_all_results();
      chan = ($urandom_range(4) == 0) ? 3'($urandom_range(7)) : 3'($urandom_range(4, 1));
      set_config(1'($urandom_range(1)), chan);
      repeat (BLOCK_ITEMS) send_snapshot(random_snapshot());
    end
    wait_all_results();
  endtask

  // The receiver holds off for a long stretch while snapshots keep coming,
  // so the pipeline fills and must stall its input without losing anything.
  task automatic test_backpressure_fill();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    wait_all_results();
    set_config(1'b1, 3'd2);
    long_stall_req = 1'b1;
    repeat (60) send_snapshot(random_snapshot());
    wait_all_results();
  endtask

  // Result side: ready is random per cycle, except during a requested
  // hold-off, which this process counts out itself.
  initial begin : drive_ready
    forever begin
      @(posedge clk);
      if (long_stall_req) begin
        long_stall_req = 1'b0;
        for (int c = 0; c < LONG_STALL; c++) begin
          out_tready <= 1'b0;
          @(posedge clk);
        end
      end
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Every accepted result transaction is compared with the oldest prediction.
  always @(posedge clk) begin : check_results
    limit_result_t got;
    limit_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata[19:0];
      if (out_tdata[23:20] != 0)
        report_mismatch("tdata padding", 64'(0), 64'(out_tdata[23:20]));
      if (pending_limits.size() == 0) begin
        report_mismatch("result with none pending, limit", 64'(0), 64'(got.scaled_limit));
      end else begin
        want = pending_limits.pop_front();
        if (got.scaled_limit != want.scaled_limit)
          report_mismatch("scaled_limit", 64'(want.scaled_limit), 64'(got.scaled_limit));
        if (got.reason != want.reason)
          report_mismatch("reason", 64'(want.reason), 64'(got.reason));
        reasons_seen[want.reason] = 1'b1;
        results_checked++;
      end
    end
  end

  // Ends the run if no transaction moves on either side for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet = 0;
      else quiet++;
    end
    $display("Timeout: no transaction for %0d cycles, %0d results pending",
             STALL_LIMIT, pending_limits.size());
    $display("end of test: mismatches");
    $finish;
  end

  initial begin
    // All block inputs start from known values before the first edge.
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    out_tready = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    overscale_mode = 1'b0;
    channels_per_mppt = 3'd1;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    long_stall_req = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_plain_directed();
    test_shading_directed();
    test_channel_extremes();
    test_random_traffic(25, 64, 400);
    test_random_traffic(64, 25, 400);
    test_random_traffic(0, 0, 400);
    test_backpressure_fill();

    // Give any stray result a chance to show up after the last prediction.
    wait_all_results();
    repeat (2 * LATENCY) @(posedge clk);
    if (pending_limits.size() != 0)
      report_mismatch("results never returned", 64'(0), 64'(pending_limits.size()));

    $display("Run covered %0d snapshots and %0d checked results over %0d register settings.",
             snapshots_sent, results_checked, config_writes);
    $display("Reason codes returned, one bit per code from bit 0: %b", reasons_seen[9:0]);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

`default_nettype wire
